### rtl/min_swaps_pkg.sv
// Package for the minimum-swaps block: default sizes and result width.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package min_swaps_pkg;
   localparam int MAX_ITEMS_DEF  = 256;
   localparam int VALUE_BITS_DEF = 32;
   localparam int SWAP_BITS      = 8;
endpackage

`default_nettype wire

### rtl/min_swaps_to_sort.sv
// Minimum swaps to sort a list: load, rank sort and cycle walk over two memories.
// Depends on min_swaps_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Values are loaded one per cycle into a value memory; items beyond MAX_ITEMS
// are dropped. The transfer with last_item set starts the computation and the
// input stalls until it is done. Each element is placed by counting the
// elements ranked below it, with one value memory read per comparison. The
// permutation is then walked through the origin memory, whose entries carry
// a visited bit. The result equals n minus the number of permutation cycles,
// saturated at 255, and is held in an output register while the next list
// loads.
module min_swaps_to_sort
   import min_swaps_pkg::*;
#(
   parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic signed [VALUE_BITS-1:0] req_value,
   input  wire logic                         req_last_item,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [SWAP_BITS-1:0]              rsp_swap_count
);
   localparam int IW = $clog2(MAX_ITEMS);
   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam logic [VALUE_BITS-1:0] SIGN_BIT = VALUE_BITS'(1) << (VALUE_BITS - 1);

   typedef enum logic [3:0] {
      LOAD, KEY_RD, KEY_CAP, SCAN_RD, SCAN_CMP, PLACE,
      WST, WST_CHK, W_RD, W_CHK, EMIT
   } state_type;

   state_type           state_ff;
   logic [CW-1:0]       count_ff;
   logic [CW-1:0]       i_ff, j_ff, rank_ff, cyc_ff;
   logic [IW-1:0]       walk_ff;
   logic [VALUE_BITS-1:0] key_ff;
   logic                rsp_valid_ff;
   logic [SWAP_BITS-1:0] swap_ff;

   logic [VALUE_BITS-1:0] val_mem [MAX_ITEMS];
   logic [IW:0]           org_mem [MAX_ITEMS];
   logic [VALUE_BITS-1:0] vrd_ff;
   logic [IW:0]           ord_ff;
   logic [IW-1:0]         vra, ora, owa;
   logic [IW:0]           owd;
   logic                  vwe, owe;
   logic                  accept, last_i, vis, lower;
   logic [VALUE_BITS-1:0] vkey;
   logic [CW-1:0]         diff;
   logic [CW+SWAP_BITS-1:0] diff_ext;

   assign req_ready      = (state_ff == LOAD);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_swap_count = swap_ff;
   assign accept         = req_valid && req_ready;
   assign vwe            = accept && (count_ff < CW'(MAX_ITEMS));
   assign last_i         = (i_ff == count_ff - CW'(1));
   assign vis            = ord_ff[IW];
   assign vkey           = vrd_ff ^ SIGN_BIT;
   assign lower          = (vkey < key_ff) || ((vkey == key_ff) && (j_ff < i_ff));
   assign diff           = count_ff - cyc_ff;
   assign diff_ext       = {{SWAP_BITS{1'b0}}, diff};

   always_comb begin
      vra = i_ff[IW-1:0];
      if (state_ff == SCAN_RD) begin
         vra = j_ff[IW-1:0];
      end
   end

   always_comb begin
      ora = i_ff[IW-1:0];
      owa = walk_ff;
      owd = {1'b1, ord_ff[IW-1:0]};
      owe = 1'b0;
      unique case (state_ff)
         W_RD: ora = walk_ff;
         PLACE: begin
            owa = rank_ff[IW-1:0];
            owd = {1'b0, i_ff[IW-1:0]};
            owe = 1'b1;
         end
         WST_CHK: begin
            owa = i_ff[IW-1:0];
            owe = !vis;
         end
         W_CHK: owe = !vis;
         default: ;
      endcase
   end

   // memories: registered read, write lands before any later read
   always_ff @(posedge clock) begin
      if (vwe) begin
         val_mem[count_ff[IW-1:0]] <= req_value;
      end
      vrd_ff <= val_mem[vra];
      if (owe) begin
         org_mem[owa] <= owd;
      end
      ord_ff <= org_mem[ora];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= LOAD;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            LOAD: if (accept) begin
               if (vwe) begin
                  count_ff <= count_ff + CW'(1);
               end
               if (req_last_item) begin
                  i_ff     <= '0;
                  state_ff <= KEY_RD;
               end
            end
            KEY_RD: state_ff <= KEY_CAP;
            KEY_CAP: begin
               key_ff   <= vkey;
               j_ff     <= '0;
               rank_ff  <= '0;
               state_ff <= SCAN_RD;
            end
            SCAN_RD: state_ff <= SCAN_CMP;
            SCAN_CMP: begin
               if (lower) begin
                  rank_ff <= rank_ff + CW'(1);
               end
               if (j_ff == count_ff - CW'(1)) begin
                  state_ff <= PLACE;
               end else begin
                  j_ff     <= j_ff + CW'(1);
                  state_ff <= SCAN_RD;
               end
            end
            PLACE: begin
               if (last_i) begin
                  i_ff     <= '0;
                  cyc_ff   <= '0;
                  state_ff <= WST;
               end else begin
                  i_ff     <= i_ff + CW'(1);
                  state_ff <= KEY_RD;
               end
            end
            WST: state_ff <= WST_CHK;
            WST_CHK, W_CHK: begin
               if (vis) begin
                  // cycle closed or start already covered
                  if (last_i) begin
                     state_ff <= EMIT;
                  end else begin
                     i_ff     <= i_ff + CW'(1);
                     state_ff <= WST;
                  end
               end else begin
                  if (state_ff == WST_CHK) begin
                     cyc_ff <= cyc_ff + CW'(1);
                  end
                  walk_ff  <= ord_ff[IW-1:0];
                  state_ff <= W_RD;
               end
            end
            W_RD: state_ff <= W_CHK;
            EMIT: if (!rsp_valid_ff) begin
               rsp_valid_ff <= 1'b1;
               swap_ff      <= (diff_ext > (CW+SWAP_BITS)'(255)) ?
                               SWAP_BITS'(255) : diff_ext[SWAP_BITS-1:0];
               count_ff     <= '0;
               state_ff     <= LOAD;
            end
            default: state_ff <= LOAD;
         endcase
      end
   end
endmodule

`default_nettype wire

### rtl/min_swaps_chk.sv
// Port-level checker for min_swaps_to_sort, bound to the top level.
// Depends on min_swaps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module min_swaps_chk
   import min_swaps_pkg::*;
(
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_ready,
   input wire logic                 req_last_item,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire logic [SWAP_BITS-1:0] rsp_swap_count
);
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready)) else $error("not idle after reset");

   a_last_stalls: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_last_item) |=> !req_ready)
      else $error("input not stalled after last transfer");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_swap_count)))
      else $error("result dropped or changed while stalled");
endmodule

bind min_swaps_to_sort min_swaps_chk u_chk (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .req_last_item(req_last_item), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_swap_count(rsp_swap_count)
);

`default_nettype wire

### verif/tb_min_swaps_to_sort.sv
// Testbench for min_swaps_to_sort: random lists with stalls on both sides, checked
// against an in-bench swap-count scoreboard.
// Depends on min_swaps_pkg and rtl/min_swaps_to_sort.sv.
`timescale 1ns / 1ps

module tb_min_swaps_to_sort;
   import min_swaps_pkg::*;

   localparam int CAPACITY    = MAX_ITEMS_DEF;
   localparam int STALL_LIMIT = 1000000;

   // Holds the list being loaded and the swap totals still owed by the block.
   class swap_scoreboard;
      logic signed [31:0] loading[$];
      logic [SWAP_BITS-1:0] owed[$];
      int errors;

      function int min_swaps();
         int order[$];
         bit seen[$];
         int pos, len, total, j;
         for (int i = 0; i < loading.size(); i++) begin
            pos = order.size();
            order.insert(order.size(), i);
            // stable insertion: only strictly greater values move up
            while (pos > 0 && loading[order[pos-1]] > loading[i]) begin
               order[pos] = order[pos-1];
               pos--;
            end
            order[pos] = i;
            seen.insert(seen.size(), 1'b0);
         end
         total = 0;
         for (int i = 0; i < order.size(); i++) begin
            if (!seen[i]) begin
               len = 0;
               j = i;
               while (!seen[j]) begin
                  seen[j] = 1'b1;
                  j = order[j];
                  len++;
               end
               total += len - 1;
            end
         end
         return total > 255 ? 255 : total;
      endfunction

      function void note_transfer(logic signed [31:0] value, logic last);
         if (loading.size() < CAPACITY)
            loading.insert(loading.size(), value);
         if (last) begin
            owed.insert(owed.size(), SWAP_BITS'(min_swaps()));
            loading.delete();
         end
      endfunction

      function void check_result(logic [SWAP_BITS-1:0] got);
         if (owed.size() == 0) begin
            $error("swap_count: unexpected result %0d", got);
            errors++;
         end else begin
            if (got !== owed[0]) begin
               $error("swap_count: expected %0d, actual %0d", owed[0], got);
               errors++;
            end
            void'(owed.pop_front());
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [31:0] req_value = '0;
   logic req_last_item = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [SWAP_BITS-1:0] rsp_swap_count;

   swap_scoreboard sb = new();
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int items_sent = 0;
   int quiet_cycles = 0;

   min_swaps_to_sort DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_value(req_value), .req_last_item(req_last_item),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_swap_count(rsp_swap_count)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // monitors and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_transfer(req_value, req_last_item);
         if (rsp_valid && rsp_ready)
            sb.check_result(rsp_swap_count);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // valid stays up after a transfer; the next item or an idle cycle replaces it
   task automatic send_item(logic signed [31:0] value, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      req_last_item <= last;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      @(negedge clock);
   endtask

   // kinds: 0 full range, 1 tiny range (many ties), 2 extremes, 3 ascending, 4 descending
   function automatic logic signed [31:0] pick_value(int kind, int idx);
      case (kind)
         0: return $urandom;
         1: return $signed($urandom_range(6)) - 3;
         2: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
         3: return idx * 7 - 100;
         default: return 1000 - idx * 3;
      endcase
   endfunction

   task automatic send_list(int len, int kind);
      for (int i = 0; i < len; i++)
         send_item(pick_value(kind, i), i == len - 1);
   endtask

   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: single item, extremes, ties, sorted, reversed
      send_item(32'sh80000000, 1'b1);
      send_item(32'sh7fffffff, 1'b0);
      send_item(32'sh80000000, 1'b1);
      send_item(32'sh80000000, 1'b0);
      send_item(32'sh7fffffff, 1'b1);
      send_item(5, 1'b0);
      send_item(5, 1'b0);
      send_item(-1, 1'b0);
      send_item(5, 1'b1);
      send_list(5, 3);
      send_list(6, 4);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
            default: begin send_idle_pct = 12; recv_stall_pct = 12; end
         endcase
         while (items_sent < 25 + (phase + 1) * 110)
            send_list($urandom_range(9) == 0 ? $urandom_range(40, 13) : $urandom_range(12, 1),
                      $urandom_range(4));
      end
      // full store, then an overflowing list whose last three values are dropped
      send_list(CAPACITY, 0);
      send_list(CAPACITY + 3, 1);
      req_valid <= 1'b0;

      wait (sb.owed.size() == 0);
      repeat (100) @(posedge clock);
      if (sb.errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end
endmodule

### sim.f
rtl/min_swaps_pkg.sv
rtl/min_swaps_to_sort.sv
rtl/min_swaps_chk.sv
verif/tb_min_swaps_to_sort.sv
